// File: rtl/rmvt_pkg.sv
`timescale 1ns / 1ps
package rmvt_pkg;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_UPDATE  = 2'd1;
  localparam logic [1:0] FUNC_COMPARE = 2'd2;

  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_INIT_VAR = 2'd1;
  localparam logic [1:0] REG_VAR_FLR  = 2'd2;

  localparam logic [16:0] ALPHA_ONE       = 17'd65536;
  localparam logic [16:0] ALPHA_RESET     = 17'd6554;
  localparam logic [47:0] INIT_VAR_RESET  = 48'd42949673;
  localparam logic [47:0] VAR_FLOOR_RESET = 48'd429497;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MEAN_A,
    OP_MEAN_B,
    OP_MEAN_END,
    OP_SQ,
    OP_VAR_A,
    OP_VAR_B,
    OP_VAR_END,
    OP_CMP_SQ,
    OP_DEN_LL,
    OP_DEN_LH,
    OP_DEN_HH,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic var_zero;
  } dp_stat_t;

endpackage

// File: rtl/running_mean_variance_tracker.sv
`timescale 1ns / 1ps
// Running mean and variance tracker. A compare item is bound by a one-bit-a-cycle
// 128-step restoring divide of (value - sample)^2 by variance squared. One item is in
// work at a time; a result held in the output register does not block the next item.
// Register writes are taken only while no item is in work, and take precedence over
// a new item offered in the same cycle.
module running_mean_variance_tracker
  import rmvt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // sample
  input  logic [1:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [303:0] m_axis_tdata,  // last_value, running_mean, running_variance,
                                      // first_value, lowest_seen, highest_seen,
                                      // samples_seen, distance
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  logic [16:0] alpha;
  logic [47:0] init_var;
  logic [47:0] var_floor;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        busy;
  logic        done;
  logic        in_fire;
  logic [1:0]  func_q;
  logic signed [31:0] value_q, mean_q, first_q, min_q, max_q;
  logic [47:0] var_q;
  logic [31:0] count_q;
  logic [63:0] dist_q;

  assign cfg_ready     = !busy;
  assign s_axis_tready = !busy && !cfg_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      init_var  <= INIT_VAR_RESET;
      var_floor <= VAR_FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA:    alpha     <= cfg_data[16:0];
        REG_INIT_VAR: init_var  <= cfg_data;
        REG_VAR_FLR:  var_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) func_q <= s_axis_tuser;
  end

  rmvt_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_func(s_axis_tuser),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .stat, .cmd, .busy, .done
  );

  rmvt_dp u_dp (
    .clk, .rst, .cmd, .in_func(s_axis_tuser), .in_sample(s_axis_tdata),
    .alpha, .init_var, .var_floor, .stat,
    .value_q, .mean_q, .var_q, .first_q, .min_q, .max_q, .count_q, .dist_q
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (done) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {dist_q, count_q, max_q, min_q, first_q, var_q, mean_q, value_q};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_func_kept: assert property (@(posedge clk) disable iff (rst)
    busy && !$past(in_fire) |-> $stable(func_q)) else $error("func changed in flight");

endmodule

// File: rtl/rmvt_ctrl.sv
`timescale 1ns / 1ps
module rmvt_ctrl
  import rmvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [1:0] in_func,
  input  logic       out_free,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_CMP, S_DIV, S_DONE
  } state_t;

  state_t     state;
  logic [3:0] step;
  logic [6:0] iter;

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = OP_LOAD;
        end
      end
      S_UPD: begin
        unique case (step)
          4'd0: cmd.op = OP_MEAN_A;
          4'd1: cmd.op = OP_MEAN_B;
          4'd2: cmd.op = OP_MEAN_END;
          4'd3: cmd.op = OP_SQ;
          4'd4: cmd.op = OP_VAR_A;
          4'd5: cmd.op = OP_VAR_B;
          4'd6: cmd.op = OP_VAR_END;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_CMP: begin
        unique case (step)
          4'd0: cmd.op = OP_CMP_SQ;
          4'd1: cmd.op = OP_DEN_LL;
          4'd2: cmd.op = OP_DEN_LH;
          4'd3: cmd.op = OP_DEN_HH;
          4'd4: cmd.op = OP_DIV_INIT;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_DIV: begin
        cmd.op = (iter == 7'd127) ? OP_DIV_END : OP_DIV_STEP;
      end
      S_DONE: cmd.op = OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      iter  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (in_fire) begin
            priority case (in_func)
              FUNC_UPDATE:  state <= S_UPD;
              FUNC_COMPARE: state <= S_CMP;
              default:      state <= S_DONE;
            endcase
          end
        end
        S_UPD: begin
          step <= step + 4'd1;
          if (step == 4'd6) begin
            state <= S_DONE;
          end
        end
        S_CMP: begin
          step <= step + 4'd1;
          if (step == 4'd0 && stat.var_zero) begin
            state <= S_DONE;
          end else if (step == 4'd4) begin
            state <= S_DIV;
            iter  <= '0;
          end
        end
        S_DIV: begin
          iter <= iter + 7'd1;
          if (iter == 7'd127) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_from_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DONE) else $error("done without finish state");
  a_fire_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == S_IDLE) else $error("accept while busy");
  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && iter == 7'd127 |=> state == S_DONE) else $error("divide overrun");

endmodule

// File: rtl/rmvt_dp.sv
`timescale 1ns / 1ps
module rmvt_dp
  import rmvt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_sample,
  input  logic [16:0]        alpha,
  input  logic [47:0]        init_var,
  input  logic [47:0]        var_floor,
  output dp_stat_t           stat,
  output logic signed [31:0] value_q,
  output logic signed [31:0] mean_q,
  output logic [47:0]        var_q,
  output logic signed [31:0] first_q,
  output logic signed [31:0] min_q,
  output logic signed [31:0] max_q,
  output logic [31:0]        count_q,
  output logic [63:0]        dist_q
);

  logic signed [31:0] x;
  logic [16:0]        a;
  logic [16:0]        na;
  logic signed [49:0] acc;
  logic [64:0]        vacc;
  logic [63:0]        sq;
  logic [32:0]        mag;
  logic [95:0]        den;
  logic [127:0]       num;
  logic [96:0]        rem;
  logic [127:0]       quo;
  logic [96:0]        rem_sh;
  logic [97:0]        rem_sub;
  logic signed [32:0] diff;
  logic [49:0]        acc_r;
  logic [32:0]        mean_next;
  logic [47:0]        v_next;
  logic [65:0]        sq_full;
  logic [23:0]        mul_a;
  logic [23:0]        mul_b;
  logic [47:0]        mul_p;

  assign a  = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign na = ALPHA_ONE - a;
  assign stat.var_zero = (var_q == '0);

  always_comb begin
    priority if (cmd.op == OP_SQ) begin
      diff = 33'(x) - 33'(mean_q);
    end else begin
      diff = 33'(value_q) - 33'(x);
    end
    mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  assign sq_full = 66'(mag) * 66'(mag);

  // variance squared built from 24-bit halves as low-low, low-high and high-high products
  always_comb begin
    unique case (cmd.op)
      OP_DEN_LH: begin
        mul_a = var_q[47:24];
        mul_b = var_q[23:0];
      end
      OP_DEN_HH: begin
        mul_a = var_q[47:24];
        mul_b = var_q[47:24];
      end
      default: begin
        mul_a = var_q[23:0];
        mul_b = var_q[23:0];
      end
    endcase
  end

  assign mul_p = 48'(mul_a) * 48'(mul_b);

  assign acc_r     = 50'(acc) + 50'd32768;
  assign mean_next = acc_r[48:16];
  assign v_next    = vacc[63:16];
  assign rem_sh    = {rem[95:0], num[127]};
  assign rem_sub   = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      value_q <= '0;
      mean_q  <= '0;
      var_q   <= INIT_VAR_RESET;
      first_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      count_q <= '0;
      dist_q  <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          x      <= in_sample;
          dist_q <= '0;
          if (in_func == FUNC_START) begin
            value_q <= in_sample;
            mean_q  <= in_sample;
            first_q <= in_sample;
            min_q   <= in_sample;
            max_q   <= in_sample;
            var_q   <= init_var;
            count_q <= 32'd1;
          end else if (in_func == FUNC_UPDATE) begin
            value_q <= in_sample;
            if (in_sample < min_q) min_q <= in_sample;
            if (in_sample > max_q) max_q <= in_sample;
            if (count_q != '1) count_q <= count_q + 32'd1;
          end
        end
        OP_MEAN_A:   acc <= 50'(mean_q) * $signed({1'b0, na});
        OP_MEAN_B:   acc <= acc + 50'(x) * $signed({1'b0, a});
        OP_MEAN_END: mean_q <= mean_next[31:0];
        OP_SQ: begin
          sq <= sq_full[63:0];
        end
        OP_VAR_A: begin
          vacc <= 65'(var_q) * 65'(na);
          sq   <= 64'((sq + 64'd32768) >> 16);
        end
        OP_VAR_B:   vacc <= vacc + 65'(sq[47:0]) * 65'(a) + 65'd32768;
        OP_VAR_END: var_q <= (v_next < var_floor) ? var_floor : v_next;
        OP_CMP_SQ: begin
          sq <= sq_full[63:0];
          if (var_q == '0) dist_q <= '1;
        end
        OP_DEN_LL: den <= 96'(mul_p);
        OP_DEN_LH: den <= den + (96'(mul_p) << 25);
        OP_DEN_HH: den <= den + (96'(mul_p) << 48);
        OP_DIV_INIT: begin
          num <= {sq, 64'd0} >> 24;
          rem <= '0;
          quo <= '0;
        end
        OP_DIV_STEP, OP_DIV_END: begin
          num <= {num[126:0], 1'b0};
          if (!rem_sub[97]) begin
            rem <= rem_sub[96:0];
            quo <= {quo[126:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[126:0], 1'b0};
          end
          if (cmd.op == OP_DIV_END) begin
            if (quo[126:63] != '0) dist_q <= '1;
            else dist_q <= {quo[62:0], !rem_sub[97]};
          end
        end
        default: ;
      endcase
    end
  end

  a_var_floor: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op) == OP_VAR_END |-> var_q >= $past(var_floor))
    else $error("variance below floor");
  a_count_start: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op) == OP_LOAD && $past(in_func) == FUNC_START |-> count_q == 32'd1)
    else $error("count not loaded");
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op) == OP_LOAD && $past(in_func) == FUNC_START |-> min_q == max_q)
    else $error("min max mismatch");

endmodule

// File: tb/tb_running_mean_variance_tracker.sv
`timescale 1ns / 1ps
module tb_running_mean_variance_tracker;
  import rmvt_pkg::*;

  typedef struct packed {
    logic [63:0] distance;
    logic [31:0] samples_seen;
    logic [31:0] highest_seen;
    logic [31:0] lowest_seen;
    logic [31:0] first_value;
    logic [47:0] running_variance;
    logic [31:0] running_mean;
    logic [31:0] last_value;
  } track_out_t;

  class tracker_scoreboard;
    logic [16:0] alpha;
    logic [47:0] init_var, var_floor;
    logic signed [31:0] value_q, mean_q, first_q, min_q, max_q;
    logic [47:0] var_q;
    logic [31:0] count_q;
    track_out_t pending[$];
    int errors;

    function new();
      alpha = ALPHA_RESET; init_var = INIT_VAR_RESET; var_floor = VAR_FLOOR_RESET;
      value_q = 0; mean_q = 0; first_q = 0; min_q = 0; max_q = 0;
      var_q = INIT_VAR_RESET; count_q = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [47:0] data);
      case (idx)
        REG_ALPHA:    alpha = data[16:0];
        REG_INIT_VAR: init_var = data;
        REG_VAR_FLR:  var_floor = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] ratio(logic [63:0] sq, logic [47:0] v);
      logic [127:0] num, den, quo;
      if (v == 0) return '1;
      num = {64'd0, sq} << 40;
      den = {80'd0, v} * {80'd0, v};
      quo = num / den;
      return (quo[127:64] != 0) ? '1 : quo[63:0];
    endfunction

    function void note_item(logic [1:0] fn, logic signed [31:0] x);
      track_out_t r;
      logic [16:0] a;
      logic signed [63:0] acc, dx;
      logic [63:0] sq, d2;
      logic [79:0] v;
      r.distance = 0;
      case (fn)
        FUNC_START: begin
          value_q = x; mean_q = x; first_q = x; min_q = x; max_q = x;
          var_q = init_var; count_q = 1;
        end
        FUNC_UPDATE: begin
          a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
          value_q = x;
          acc = 64'(mean_q) * $signed({47'd0, 17'(ALPHA_ONE - a)})
              + 64'(x) * $signed({47'd0, a}) + 64'sd32768;
          mean_q = 32'(acc >>> 16);
          dx = 64'(x) - 64'(mean_q);
          if (dx < 0) dx = -dx;
          sq = dx * dx;
          d2 = (sq + 64'd32768) >> 16;
          v = (80'(var_q) * 80'(ALPHA_ONE - a) + 80'(d2) * 80'(a) + 80'd32768) >> 16;
          if (v < 80'(var_floor)) v = 80'(var_floor);
          var_q = v[47:0];
          if (x < min_q) min_q = x;
          if (x > max_q) max_q = x;
          if (count_q != '1) count_q++;
        end
        FUNC_COMPARE: begin
          dx = 64'(value_q) - 64'(x);
          if (dx < 0) dx = -dx;
          r.distance = ratio(dx * dx, var_q);
        end
        default: ;
      endcase
      r.last_value = value_q; r.running_mean = mean_q; r.running_variance = var_q;
      r.first_value = first_q; r.lowest_seen = min_q; r.highest_seen = max_q;
      r.samples_seen = count_q;
      pending.push_back(r);
    endfunction

    function void check_result(track_out_t got);
      track_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.last_value != exp.last_value) begin
        $display("%0t: last_value exp %h got %h", $time, exp.last_value, got.last_value);
        errors++;
      end
      if (got.running_mean != exp.running_mean) begin
        $display("%0t: running_mean exp %h got %h", $time, exp.running_mean,
                 got.running_mean);
        errors++;
      end
      if (got.running_variance != exp.running_variance) begin
        $display("%0t: running_variance exp %h got %h", $time, exp.running_variance,
                 got.running_variance);
        errors++;
      end
      if (got.first_value != exp.first_value) begin
        $display("%0t: first_value exp %h got %h", $time, exp.first_value, got.first_value);
        errors++;
      end
      if (got.lowest_seen != exp.lowest_seen) begin
        $display("%0t: lowest_seen exp %h got %h", $time, exp.lowest_seen, got.lowest_seen);
        errors++;
      end
      if (got.highest_seen != exp.highest_seen) begin
        $display("%0t: highest_seen exp %h got %h", $time, exp.highest_seen,
                 got.highest_seen);
        errors++;
      end
      if (got.samples_seen != exp.samples_seen) begin
        $display("%0t: samples_seen exp %h got %h", $time, exp.samples_seen,
                 got.samples_seen);
        errors++;
      end
      if (got.distance != exp.distance) begin
        $display("%0t: distance exp %h got %h", $time, exp.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [303:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;

  tracker_scoreboard tracker = new();
  bit sink_calm;
  int hold_off;

  running_mean_variance_tracker dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= sink_calm || ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic send_item(logic [1:0] fn, logic [31:0] x, bit calm);
    cfg_valid <= 0;
    if (!calm) begin
      while ($urandom_range(99) < 14) begin
        s_axis_tvalid <= 0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= x;
    s_axis_tuser <= fn;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_item(fn, $signed(x));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    cfg_valid <= 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  function automatic logic [31:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic random_phase(int n, bit calm);
    int mode;
    logic [1:0] fn;
    mode = $urandom_range(2);
    send_item(FUNC_START, rand_sample(mode), calm);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: fn = FUNC_START;
        1: fn = 2'd3;
        2, 3, 4, 5, 6: fn = FUNC_COMPARE;
        default: fn = FUNC_UPDATE;
      endcase
      send_item(fn, rand_sample(($urandom_range(9) == 0) ? 0 : mode), calm);
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    sink_calm = 0; hold_off = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset state: update and compare before any start, then extreme samples
    send_item(FUNC_UPDATE, 32'h0100_0000, 0);
    send_item(FUNC_COMPARE, 32'h0000_0000, 0);
    send_item(FUNC_START, 32'h8000_0000, 0);
    send_item(FUNC_UPDATE, 32'h7FFF_FFFF, 0);
    send_item(FUNC_UPDATE, 32'h8000_0000, 0);
    send_item(FUNC_COMPARE, 32'h7FFF_FFFF, 0);
    send_item(2'd3, 32'hFFFF_FFFF, 0);
    send_item(FUNC_START, 32'h7FFF_FFFF, 0);
    send_item(FUNC_COMPARE, 32'h8000_0000, 0);
    send_item(FUNC_COMPARE, 32'h7FFF_FFFF, 0);
    drain();

    // zero variance, zero floor
    write_reg(REG_INIT_VAR, 48'd0);
    write_reg(REG_VAR_FLR, 48'd0);
    send_item(FUNC_START, 32'h0000_0001, 0);
    send_item(FUNC_COMPARE, 32'h0000_0002, 0);
    send_item(FUNC_COMPARE, 32'h0000_0001, 0);
    drain();

    // alpha beyond one, extremes of variance
    write_reg(REG_ALPHA, 17'h1FFFF);
    write_reg(REG_INIT_VAR, '1);
    write_reg(REG_VAR_FLR, '1);
    send_item(FUNC_START, 32'h8000_0000, 0);
    send_item(FUNC_UPDATE, 32'h7FFF_FFFF, 0);
    send_item(FUNC_COMPARE, 32'h8000_0000, 0);
    drain();
    write_reg(REG_ALPHA, 17'd0);
    write_reg(REG_VAR_FLR, 48'd1);
    send_item(FUNC_START, 32'h1234_5678, 0);
    send_item(FUNC_UPDATE, 32'hEDCB_A988, 0);
    send_item(FUNC_COMPARE, 32'h0000_0000, 0);
    drain();

    // long result stall: block fills and holds off its input
    write_reg(REG_ALPHA, ALPHA_ONE);
    write_reg(REG_INIT_VAR, INIT_VAR_RESET);
    write_reg(REG_VAR_FLR, VAR_FLOOR_RESET);
    hold_off = 400;
    random_phase(20, 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      write_reg(REG_ALPHA, ($urandom_range(3) == 0) ? 17'($urandom()) :
                17'($urandom_range(65536)));
      write_reg(REG_INIT_VAR, ($urandom_range(1)) ? 48'({$urandom(), $urandom()}) :
                48'($urandom_range(1 << 30)));
      write_reg(REG_VAR_FLR, ($urandom_range(3) == 0) ? 48'({$urandom(), $urandom()}) :
                48'($urandom_range(1 << 20)));
      sink_calm = (p == 5);
      random_phase(110, p == 5);
      drain();
    end

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/rmvt_pkg.sv
rtl/rmvt_ctrl.sv
rtl/rmvt_dp.sv
rtl/running_mean_variance_tracker.sv
tb/tb_running_mean_variance_tracker.sv
